@@ hdl/fir32_pkg.sv @@
// Shared constants, types and the coefficient table of the 32-tap FIR filter.
// Used by fir32_cell, fir32_mac and the top level; depends on nothing else.
`default_nettype none
package fir32_pkg;

	localparam int TAPS        = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int COEF_SHIFT  = 12;
	localparam int ROM_COUNT   = 32;
	localparam int TAP_IDX_W   = $clog2(TAPS);
	localparam int ROM_IDX_W   = $clog2(ROM_COUNT);
	localparam int COEF_IDX_W  = 8;
	localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W       = PROD_W + TAP_IDX_W + 1;
	localparam int SH_W        = ACC_W - COEF_SHIFT;

	// Coefficients, signed Q4.12
	localparam logic signed [COEF_BITS-1:0] COEF_ROM [ROM_COUNT] = '{
		16'sd12033, -16'sd555,  -16'sd1437, -16'sd1297, -16'sd2827, 16'sd103,   16'sd45,    -16'sd421,
		16'sd74,    -16'sd668,  16'sd350,   -16'sd578,  16'sd118,   -16'sd666,  -16'sd550,  16'sd1016,
		16'sd179,   16'sd243,   -16'sd1051, -16'sd1213, -16'sd328,  -16'sd394,  -16'sd158,  -16'sd587,
		-16'sd401,  -16'sd16,   16'sd576,   16'sd1525,  -16'sd1541, -16'sd1146, -16'sd704,  16'sd521
	};

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic mul_en;
	} mac_ctrl_t;

	// Saturated result of one accumulation
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          sat;
	} mac_result_t;

	// Look up tap k; taps past the table use zero
	function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [COEF_IDX_W-1:0] k);
		logic signed [COEF_BITS-1:0] c;
		c = '0;
		if (k < COEF_IDX_W'(ROM_COUNT)) begin
			c = COEF_ROM[k[ROM_IDX_W-1:0]];
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hdl/fir32_cell.sv @@
// One delay-line cell: a sample register that takes its neighbor's value on advance.
// Depends on fir32_pkg for the sample width.
`default_nettype none
module fir32_cell (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    shift_en,
	input  wire logic signed [fir32_pkg::SAMPLE_BITS-1:0] d,
	output logic signed [fir32_pkg::SAMPLE_BITS-1:0]      q
);

	logic signed [fir32_pkg::SAMPLE_BITS-1:0] sample_q;

	// Advance the sample from the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule
`default_nettype wire

@@ hdl/fir32_mac.sv @@
// Multiply-accumulate unit: registered product, wide accumulator, shift and saturate.
// Depends on fir32_pkg for widths and the control/result structs.
`default_nettype none
module fir32_mac (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire fir32_pkg::mac_ctrl_t                     ctrl,
	input  wire logic signed [fir32_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic signed [fir32_pkg::COEF_BITS-1:0]   coef,
	output fir32_pkg::mac_result_t                        result
);

	localparam logic signed [fir32_pkg::SH_W-1:0] SH_MAX =
		fir32_pkg::SH_W'((64'sd1 <<< (fir32_pkg::SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [fir32_pkg::SH_W-1:0] SH_MIN = -SH_MAX - 1;

	logic signed [fir32_pkg::PROD_W-1:0] prod_s1;
	logic                                prod_valid_s1;
	logic signed [fir32_pkg::ACC_W-1:0]  acc_q;
	logic signed [fir32_pkg::SH_W-1:0]   shifted;

	// Register the product of one tap
	always_ff @(posedge clk) begin
		prod_s1 <= sample * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s1 <= 1'b0;
		end else begin
			prod_valid_s1 <= ctrl.mul_en;
		end
	end

	// Accumulate registered products; clear at the start of a sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_valid_s1) begin
			acc_q <= acc_q + fir32_pkg::ACC_W'(prod_s1);
		end
	end

	// Drop the fraction bits (floor) and clip to the sample range
	always_comb begin
		shifted      = acc_q[fir32_pkg::ACC_W-1:fir32_pkg::COEF_SHIFT];
		result.sat   = 1'b0;
		result.value = shifted[fir32_pkg::SAMPLE_BITS-1:0];
		if (shifted > SH_MAX) begin
			result.sat   = 1'b1;
			result.value = SH_MAX[fir32_pkg::SAMPLE_BITS-1:0];
		end else if (shifted < SH_MIN) begin
			result.sat   = 1'b1;
			result.value = SH_MIN[fir32_pkg::SAMPLE_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

@@ hdl/fir_filter_32tap_fixed_coef_top.sv @@
// Top level of the 32-tap fixed-coefficient FIR filter: delay-line ring of cells,
// sequencer and output register. Depends on fir32_pkg, fir32_cell and fir32_mac.
//
// Usage:
//   Input channel sample_in / in_valid / in_ready takes one signed Q1.15 sample
//   per request. Output channel sample_out, saturated / out_valid / out_ready
//   returns one filtered, saturated sample per input, in order.
//   The samples live in a ring of 32 cells, tap 0 in the first cell. A new
//   sample shifts into the ring; then the ring rotates once per cycle through
//   all taps, so each tap passes the last cell and meets one multiplier while the
//   ring comes back to where it started.
//   Order of events: the shift happens at the input request edge; then the
//   ring rotates and multiplies, the accumulator drains, and the result is
//   saturated and loaded. One sample is in flight at a time, set by the
//   single shared multiplier walking the 32 taps: a new sample is taken only
//   when the sequencer is back in idle.
//   A finished result waits in the output register; the next sample is taken
//   meanwhile, and only its own result waits for out_ready.
//   Reset (arst_n low) clears the delay line, the sequencer and out_valid.
`default_nettype none
module fir_filter_32tap_fixed_coef_top (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic signed [fir32_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	output logic signed [fir32_pkg::SAMPLE_BITS-1:0]      sample_out,
	output logic                                         saturated,
	output logic                                         out_valid,
	input  wire logic                                    out_ready
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;
	localparam logic [fir32_pkg::TAP_IDX_W-1:0] LAST_TAP = fir32_pkg::TAP_IDX_W'(fir32_pkg::TAPS - 1);

	logic [1:0]                               state_q;
	logic [fir32_pkg::TAP_IDX_W-1:0]          step_q;
	logic                                     in_fire;
	logic                                     out_free;
	logic                                     shift_en;
	logic signed [fir32_pkg::SAMPLE_BITS-1:0] tap_q [fir32_pkg::TAPS];
	logic signed [fir32_pkg::SAMPLE_BITS-1:0] ring_in;
	logic [fir32_pkg::TAP_IDX_W-1:0]          coef_idx;
	logic signed [fir32_pkg::COEF_BITS-1:0]   coef;
	fir32_pkg::mac_ctrl_t                     mac_ctrl;
	fir32_pkg::mac_result_t                   mac_res;
	logic signed [fir32_pkg::SAMPLE_BITS-1:0] sample_out_q;
	logic                                     saturated_q;
	logic                                     out_valid_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Shift in a new sample, or rotate the ring during the tap walk
	assign shift_en = in_fire || (state_q == ST_RUN);
	assign ring_in  = in_fire ? sample_in : tap_q[fir32_pkg::TAPS-1];

	for (genvar i = 0; i < fir32_pkg::TAPS; i++) begin : g_cell
		if (i == 0) begin : g_head
			fir32_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (ring_in),
				.q        (tap_q[i])
			);
		end else begin : g_body
			fir32_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (tap_q[i-1]),
				.q        (tap_q[i])
			);
		end
	end

	// The last cell holds tap (TAPS-1-step) at step step
	assign coef_idx = LAST_TAP - step_q;
	assign coef     = fir32_pkg::coef_at(fir32_pkg::COEF_IDX_W'(coef_idx));

	assign mac_ctrl.clear  = in_fire;
	assign mac_ctrl.mul_en = (state_q == ST_RUN);

	fir32_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (tap_q[fir32_pkg::TAPS-1]),
		.coef   (coef),
		.result (mac_res)
	);

	// Sequence: shift in, walk the taps, drain the product, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_TAP) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			sample_out_q <= mac_res.value;
			saturated_q  <= mac_res.sat;
		end
	end

	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;
	assign out_valid  = out_valid_q;

endmodule
`default_nettype wire

@@ dv/tb_fir_filter_32tap_fixed_coef_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fir_filter_32tap_fixed_coef_top: drives samples over valid/ready,
// predicts each filtered sample in a local 32-tap FIR model and checks results in order.
// Depends on fir32_pkg (sample width) and the top-level RTL.
module tb_fir_filter_32tap_fixed_coef_top;

	localparam int     SAMPLE_BITS    = fir32_pkg::SAMPLE_BITS;
	localparam int     TAP_COUNT      = 32;
	localparam int     FRAC_SHIFT     = 12;
	localparam longint SAMPLE_MAX     = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     END_SETTLE     = 60;

	// Q4.12 tap weights, tap 0 applies to the newest sample
	localparam int TAP_COEF [TAP_COUNT] = '{
		12033, -555, -1437, -1297, -2827, 103, 45, -421,
		74, -668, 350, -578, 118, -666, -550, 1016,
		179, 243, -1051, -1213, -328, -394, -158, -587,
		-401, -16, 576, 1525, -1541, -1146, -704, 521
	};

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_PERIODIC
	} ready_mode_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          sat;
	} filtered_t;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          saturated;
	logic                          out_valid;
	logic                          out_ready = 1'b0;

	// Model state: sample history ring and the slot the next sample fills
	logic signed [SAMPLE_BITS-1:0] tap_history [TAP_COUNT] = '{default: '0};
	logic [4:0]                    next_slot = '0;
	filtered_t                     pending_outputs [$];

	int          err_count   = 0;
	int          idle_cycles = 0;
	logic        hold_req    = 1'b0;
	logic        hold_served = 1'b0;
	int          hold_left   = 0;
	logic [31:0] rx_cycle    = '0;
	ready_mode_t ready_mode  = READY_ALWAYS;

	fir_filter_32tap_fixed_coef_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_out (sample_out),
		.saturated  (saturated),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Push a sample into the history and return the filtered, saturated output
	function automatic filtered_t fir_filter_step(input logic signed [SAMPLE_BITS-1:0] x);
		longint     acc;
		longint     y;
		logic [4:0] idx;
		filtered_t  r;
		tap_history[next_slot] = x;
		next_slot = next_slot + 5'd1;
		idx = next_slot;
		acc = 0;
		for (int k = 0; k < TAP_COUNT; k++) begin
			idx = idx - 5'd1;
			acc += longint'(TAP_COEF[k]) * longint'(tap_history[idx]);
		end
		y = acc >>> FRAC_SHIFT;
		r.sat = 1'b0;
		if (y > SAMPLE_MAX) begin
			y = SAMPLE_MAX;
			r.sat = 1'b1;
		end else if (y < SAMPLE_MIN) begin
			y = SAMPLE_MIN;
			r.sat = 1'b1;
		end
		r.value = y[SAMPLE_BITS-1:0];
		return r;
	endfunction

	// Predict on each input request, check each output request against the oldest prediction
	always @(posedge clk) begin
		filtered_t exp_out;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_outputs.push_back(fir_filter_step(sample_in));
			end
			if (out_valid && out_ready) begin
				if (pending_outputs.size() == 0) begin
					$display("%0t: unexpected output: sample_out %0d saturated %0b",
						$time, sample_out, saturated);
					err_count++;
				end else begin
					exp_out = pending_outputs.pop_front();
					if (sample_out !== exp_out.value) begin
						$display("%0t: sample_out mismatch: expected %0d, actual %0d",
							$time, exp_out.value, sample_out);
						err_count++;
					end
					if (saturated !== exp_out.sat) begin
						$display("%0t: saturated mismatch: expected %0b, actual %0b",
							$time, exp_out.sat, saturated);
						err_count++;
					end
				end
			end
		end
	end

	// Abort when no request moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d outputs outstanding",
				$time, pending_outputs.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Output side: long hold-off on request, otherwise a stall pattern that is redrawn at random
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle[7:0] == 8'd0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
		end
		if (!hold_req) begin
			hold_served <= 1'b0;
		end
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_served) begin
			out_ready   <= 1'b0;
			hold_left   <= HOLD_CYCLES;
			hold_served <= 1'b1;
		end else begin
			case (ready_mode)
				READY_ALWAYS:   out_ready <= 1'b1;
				READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
				READY_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
				READY_PERIODIC: out_ready <= (rx_cycle[5:3] != 3'd0);
				default:        out_ready <= 1'b1;
			endcase
		end
	end

	// Raise valid with the sample and hold until the request is taken
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
		sample_in <= x;
		in_valid  <= 1'b1;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	task automatic pause_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted output has come back
	task automatic wait_outputs_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	// Mix of full-scale, mid-scale, small, extreme and single-bit samples
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		logic signed [SAMPLE_BITS-1:0] s;
		case ($urandom_range(0, 9))
			0, 1, 2: s = SAMPLE_BITS'($urandom());
			3, 4, 5: s = SAMPLE_BITS'($signed($urandom_range(0, 2047)) - 1024);
			6, 7:    s = SAMPLE_BITS'($signed($urandom_range(0, 16383)) - 8192);
			8: begin
				case ($urandom_range(0, 4))
					0:       s = 16'sh7fff;
					1:       s = 16'sh8000;
					2:       s = 16'sh0000;
					3:       s = 16'shffff;
					default: s = 16'sh0001;
				endcase
			end
			default: s = 16'sh0001 <<< $urandom_range(0, SAMPLE_BITS - 1);
		endcase
		return s;
	endfunction

	// Full-scale steps drive the sum past both rails
	task automatic test_clip_extremes();
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh0001);
		send_sample(16'shffff);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		wait_outputs_drained();
	endtask

	// Unit impulse followed by zeros walks the first 15 tap weights out one by one, on top of earlier samples
	task automatic test_impulse();
		send_sample(16'sh1000);
		repeat (14) send_sample(16'sh0000);
		wait_outputs_drained();
	endtask

	// Random samples in bursts with random gaps, some bursts with no gap at all
	task automatic test_random_stream(input int count);
		int burst_left;
		burst_left = $urandom_range(1, 20);
		for (int i = 0; i < count; i++) begin
			send_sample(pick_sample());
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				if ($urandom_range(0, 2) != 0) begin
					pause_input($urandom_range(1, 80));
				end
			end
		end
		wait_outputs_drained();
	endtask

	// Stall the output for a long stretch while input keeps offering back to back
	task automatic test_output_backpressure(input int count);
		hold_req <= 1'b1;
		for (int i = 0; i < count; i++) begin
			send_sample(pick_sample());
		end
		hold_req <= 1'b0;
		wait_outputs_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clip_extremes();
		test_impulse();
		test_random_stream(600);
		test_output_backpressure(24);
		test_random_stream(550);
		test_output_backpressure(24);
		test_random_stream(550);

		wait_outputs_drained();
		repeat (END_SETTLE) @(posedge clk);
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
